[rtl/bpa_pkg.sv]
`default_nettype none
package bpa_pkg;

	localparam int DEF_POOL_PAGES = 4096;
	localparam int DEF_MAX_RUN    = 64;
	localparam int DEF_PAGE_BYTES = 4096;

	localparam int BASE_W  = 20;
	localparam int POOL_W  = 13;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 3;
	localparam int ADDR_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [BASE_W-1:0] RST_VIRT_BASE  = 20'd786688;
	localparam logic [BASE_W-1:0] RST_PHYS_BASE  = 20'd512;
	localparam logic [POOL_W-1:0] RST_POOL_PAGES = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_COUNT   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_UNSUPPORTED = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NO_VIRT     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NO_PHYS     = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_VREQ,
		ST_VSCAN,
		ST_MREQ,
		ST_MWR,
		ST_PREQ,
		ST_PCHK,
		ST_EMIT_OK,
		ST_EMIT_ERR
	} bpa_state_t;

	typedef struct packed {
		logic              clr_write;
		logic              clr_step;
		logic              take;
		logic              err_set;
		logic [STAT_W-1:0] err_code;
		logic              vinit;
		logic              vread;
		logic              vscan;
		logic              mread;
		logic              mwrite;
		logic              pinit;
		logic              pread;
		logic              pcheck;
		logic              emit_ok;
		logic              emit_err;
	} bpa_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad_count;
		logic user_req;
		logic v_end;
		logic v_found;
		logic v_stop;
		logic chunk_last;
		logic m_last;
		logic p_end;
		logic p_found;
		logic out_free;
		logic last_page;
	} bpa_stat_t;

endpackage
`default_nettype wire

[rtl/bpa_ram.sv]
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/bpa_ctrl.sv]
`default_nettype none
module bpa_ctrl import bpa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bpa_stat_t stat,
	output bpa_cmd_t       cmd
);

	bpa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				cmd.clr_step  = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.bad_count) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = STAT_BAD_COUNT;
					state_d      = ST_EMIT_ERR;
				end else if (stat.user_req) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = STAT_UNSUPPORTED;
					state_d      = ST_EMIT_ERR;
				end else begin
					cmd.vinit = 1'b1;
					state_d   = ST_VREQ;
				end
			end
			ST_VREQ: begin
				if (stat.v_end) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = STAT_NO_VIRT;
					state_d      = ST_EMIT_ERR;
				end else begin
					cmd.vread = 1'b1;
					state_d   = ST_VSCAN;
				end
			end
			ST_VSCAN: begin
				cmd.vscan = 1'b1;
				if (stat.v_found) begin
					state_d = ST_MREQ;
				end else if (stat.v_stop) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = STAT_NO_VIRT;
					state_d      = ST_EMIT_ERR;
				end else if (stat.chunk_last) begin
					state_d = ST_VREQ;
				end
			end
			ST_MREQ: begin
				cmd.mread = 1'b1;
				state_d   = ST_MWR;
			end
			ST_MWR: begin
				cmd.mwrite = 1'b1;
				if (stat.m_last) begin
					cmd.pinit = 1'b1;
					state_d   = ST_PREQ;
				end else begin
					state_d = ST_MREQ;
				end
			end
			ST_PREQ: begin
				if (stat.p_end) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = STAT_NO_PHYS;
					state_d      = ST_EMIT_ERR;
				end else begin
					cmd.pread = 1'b1;
					state_d   = ST_PCHK;
				end
			end
			ST_PCHK: begin
				cmd.pcheck = 1'b1;
				state_d    = stat.p_found ? ST_EMIT_OK : ST_PREQ;
			end
			ST_EMIT_OK: begin
				if (stat.out_free) begin
					cmd.emit_ok = 1'b1;
					state_d     = stat.last_page ? ST_IDLE : ST_PREQ;
				end
			end
			ST_EMIT_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/bpa_dp.sv]
`default_nettype none
module bpa_dp import bpa_pkg::*; #(
	parameter int POOL_PAGES = DEF_POOL_PAGES,
	parameter int MAX_RUN    = DEF_MAX_RUN,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES,
	localparam int MAP_WORDS = (POOL_PAGES + 31) / 32,
	localparam int IDX_W     = $clog2(POOL_PAGES),
	localparam int AW        = (IDX_W > 5) ? IDX_W - 5 : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bpa_cmd_t             cmd,
	output bpa_stat_t                 stat,
	input  wire logic                 in_user,
	input  wire logic [COUNT_W-1:0]   in_count,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [BASE_W-1:0]    cfg_wdata,
	output logic                      v_we,
	output logic      [AW-1:0]        v_waddr,
	output logic      [31:0]          v_wdata,
	output logic                      v_re,
	output logic      [AW-1:0]        v_raddr,
	input  wire logic [31:0]          v_rdata,
	output logic                      p_we,
	output logic      [AW-1:0]        p_waddr,
	output logic      [31:0]          p_wdata,
	output logic                      p_re,
	output logic      [AW-1:0]        p_raddr,
	input  wire logic [31:0]          p_rdata,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [STAT_W-1:0]    out_status,
	output logic      [ADDR_W-1:0]    out_virt_addr,
	output logic      [ADDR_W-1:0]    out_phys_addr,
	output logic                      out_last
);

	localparam int CW    = AW + 6;
	localparam int LIM_W = $clog2(POOL_PAGES + 1);
	localparam int LW2   = (LIM_W > POOL_W) ? LIM_W : POOL_W;
	localparam int SH    = $clog2(PAGE_BYTES);

	logic [BASE_W-1:0]  virt_base_q, phys_base_q;
	logic [POOL_W-1:0]  pool_q;
	logic [COUNT_W-1:0] cnt_q, run_q, k_q;
	logic               user_q;
	logic [STAT_W-1:0]  err_q;
	logic [AW:0]        w_q, hint_q;
	logic [1:0]         chunk_q;
	logic [CW-1:0]      start_q, f_q;
	logic [AW-1:0]      clr_q;

	logic               out_valid_q, out_last_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [ADDR_W-1:0]  out_va_q, out_pa_q;

	logic [LW2-1:0] pool_ext, lim_c;
	logic [CW-1:0]  lim_ext, wbase, cb, rem, end_c;

	assign pool_ext = LW2'(pool_q);
	assign lim_c    = (pool_ext > LW2'(POOL_PAGES)) ? LW2'(POOL_PAGES) : pool_ext;
	assign lim_ext  = CW'(lim_c);
	assign wbase    = {w_q, 5'd0};
	assign cb       = {w_q, chunk_q, 3'd0};

	// first-fit run tracking over one byte of the word
	logic [7:0]         chunk_bits;
	logic [COUNT_W-1:0] run_c;
	logic               fnd_c, stop_c;
	logic [CW-1:0]      st_c;

	always_comb begin
		logic [CW-1:0] idx;
		chunk_bits = 8'(v_rdata >> {chunk_q, 3'd0});
		run_c  = run_q;
		fnd_c  = 1'b0;
		stop_c = 1'b0;
		st_c   = '0;
		for (int j = 0; j < 8; j++) begin
			idx = cb + CW'(j);
			if (!fnd_c && !stop_c) begin
				if (idx >= lim_ext) begin
					stop_c = 1'b1;
				end else if (chunk_bits[j]) begin
					run_c = '0;
				end else begin
					run_c = run_c + COUNT_W'(1);
					if (run_c == cnt_q) begin
						fnd_c = 1'b1;
						st_c  = idx + CW'(1) - CW'(cnt_q);
					end
				end
			end
		end
	end

	// mask of the granted run inside the current word
	logic [AW:0]   ws, we_w;
	logic [4:0]    lo, hi;
	logic [31:0]   run_mask;

	assign end_c    = start_q + CW'(cnt_q) - CW'(1);
	assign ws       = start_q[CW-1:5];
	assign we_w     = end_c[CW-1:5];
	assign lo       = (w_q == ws) ? start_q[4:0] : 5'd0;
	assign hi       = (w_q == we_w) ? end_c[4:0] : 5'd31;
	assign run_mask = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (5'd31 - hi));

	// lowest free frame in the current word, frames past the limit count as used
	logic [31:0] beyond, masked, new_word;
	logic [4:0]  lz;
	logic        pfound, full_after;

	assign rem    = lim_ext - wbase;
	assign beyond = (rem >= CW'(32)) ? 32'd0 : (32'hFFFF_FFFF << rem[4:0]);
	assign masked = p_rdata | beyond;
	assign pfound = (masked != 32'hFFFF_FFFF);

	always_comb begin
		lz = 5'd0;
		for (int j = 31; j >= 0; j--) begin
			if (!masked[j]) begin
				lz = 5'(j);
			end
		end
	end

	assign new_word   = p_rdata | (32'd1 << lz);
	assign full_after = pfound ? (&new_word) : (&p_rdata);

	logic [31:0] va_page, pa_page;
	assign va_page = 32'(virt_base_q) + 32'(start_q) + 32'(k_q);
	assign pa_page = 32'(phys_base_q) + 32'(f_q);

	always_comb begin
		stat            = '0;
		stat.clr_last   = (clr_q == AW'(MAP_WORDS - 1));
		stat.bad_count  = (cnt_q == '0) || (cnt_q > COUNT_W'(MAX_RUN));
		stat.user_req   = user_q;
		stat.v_end      = (wbase >= lim_ext);
		stat.v_found    = fnd_c;
		stat.v_stop     = stop_c;
		stat.chunk_last = (chunk_q == 2'd3);
		stat.m_last     = (w_q == we_w);
		stat.p_end      = (wbase >= lim_ext);
		stat.p_found    = pfound;
		stat.out_free   = !out_valid_q || out_ready;
		stat.last_page  = (COUNT_W'(k_q + COUNT_W'(1)) == cnt_q);
	end

	assign v_we    = cmd.clr_write | cmd.mwrite;
	assign v_waddr = cmd.clr_write ? clr_q : w_q[AW-1:0];
	assign v_wdata = cmd.clr_write ? 32'd0 : (v_rdata | run_mask);
	assign v_re    = cmd.vread | cmd.mread;
	assign v_raddr = w_q[AW-1:0];

	assign p_we    = cmd.clr_write | (cmd.pcheck & pfound);
	assign p_waddr = cmd.clr_write ? clr_q : w_q[AW-1:0];
	assign p_wdata = cmd.clr_write ? 32'd0 : new_word;
	assign p_re    = cmd.pread;
	assign p_raddr = w_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			virt_base_q <= RST_VIRT_BASE;
			phys_base_q <= RST_PHYS_BASE;
			pool_q      <= RST_POOL_PAGES;
			clr_q       <= '0;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_VIRT_BASE:  virt_base_q <= cfg_wdata;
					CFG_PHYS_BASE:  phys_base_q <= cfg_wdata;
					CFG_POOL_PAGES: pool_q      <= cfg_wdata[POOL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			// skip words that are completely taken on later scans
			if (cmd.pcheck && (w_q == hint_q) && full_after) begin
				hint_q <= hint_q + (AW+1)'(1);
			end
			if (cmd.emit_ok || cmd.emit_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cnt_q  <= in_count;
			user_q <= in_user;
		end
		if (cmd.err_set) begin
			err_q <= cmd.err_code;
		end
		if (cmd.vinit) begin
			w_q     <= '0;
			chunk_q <= 2'd0;
			run_q   <= '0;
		end
		if (cmd.vscan) begin
			if (fnd_c) begin
				start_q <= st_c;
				w_q     <= st_c[CW-1:5];
			end else begin
				run_q   <= run_c;
				chunk_q <= chunk_q + 2'd1;
				if (chunk_q == 2'd3) begin
					w_q <= w_q + (AW+1)'(1);
				end
			end
		end
		if (cmd.mwrite && !cmd.pinit) begin
			w_q <= w_q + (AW+1)'(1);
		end
		if (cmd.pinit) begin
			w_q <= hint_q;
			k_q <= '0;
		end
		if (cmd.pcheck) begin
			if (pfound) begin
				f_q <= {w_q, lz};
			end else begin
				w_q <= w_q + (AW+1)'(1);
			end
		end
		if (cmd.emit_ok) begin
			k_q          <= k_q + COUNT_W'(1);
			out_status_q <= STAT_OK;
			out_va_q     <= 32'(va_page << SH);
			out_pa_q     <= 32'(pa_page << SH);
			out_last_q   <= stat.last_page;
		end
		if (cmd.emit_err) begin
			out_status_q <= err_q;
			out_va_q     <= '0;
			out_pa_q     <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_virt_addr = out_va_q;
	assign out_phys_addr = out_pa_q;
	assign out_last      = out_last_q;

endmodule
`default_nettype wire

[rtl/bitmap_page_allocator_unit.sv]
// After reset both bitmaps are cleared word by word (MAP_WORDS words, 128 by default), and no
// request is taken meanwhile. A rejected request goes from ST_CHECK to ST_EMIT_ERR for its item.
// The first-fit search reads each 32-page bitmap word and scans it one byte a cycle, marking
// reads and writes back each touched word, and each page then reads frame words from the
// physical bitmap until a free frame is found and emits its item once the output is free.
// One request is in work at a time; the bitmap RAM read ports set the pace.
`default_nettype none
module bitmap_page_allocator_unit import bpa_pkg::*; #(
	parameter int POOL_PAGES = DEF_POOL_PAGES,
	parameter int MAX_RUN    = DEF_MAX_RUN,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,  // req_pages[6:0], zero bit 7
	input  wire logic [0:0]           s_axis_tuser,  // user_pool
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [63:0]          m_axis_tdata,  // virt_addr[31:0], phys_addr[63:32]
	output logic      [STAT_W-1:0]    m_axis_tuser,  // status
	output logic                      m_axis_tlast,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BASE_W-1:0]    cfg_data
);

	localparam int MAP_WORDS = (POOL_PAGES + 31) / 32;
	localparam int IDX_W     = $clog2(POOL_PAGES);
	localparam int AW        = (IDX_W > 5) ? IDX_W - 5 : 1;

	bpa_cmd_t  cmd;
	bpa_stat_t stat;

	logic          v_we, v_re, p_we, p_re;
	logic [AW-1:0] v_waddr, v_raddr, p_waddr, p_raddr;
	logic [31:0]   v_wdata, v_rdata, p_wdata, p_rdata;
	logic [ADDR_W-1:0] va, pa;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_dp #(
		.POOL_PAGES (POOL_PAGES),
		.MAX_RUN    (MAX_RUN),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_user       (s_axis_tuser[0]),
		.in_count      (s_axis_tdata[COUNT_W-1:0]),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_idx       (cfg_index),
		.cfg_wdata     (cfg_data),
		.v_we          (v_we),
		.v_waddr       (v_waddr),
		.v_wdata       (v_wdata),
		.v_re          (v_re),
		.v_raddr       (v_raddr),
		.v_rdata       (v_rdata),
		.p_we          (p_we),
		.p_waddr       (p_waddr),
		.p_wdata       (p_wdata),
		.p_re          (p_re),
		.p_raddr       (p_raddr),
		.p_rdata       (p_rdata),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (m_axis_tuser),
		.out_virt_addr (va),
		.out_phys_addr (pa),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {pa, va};

	bpa_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_virt_map (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.re    (v_re),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	bpa_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_phys_map (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

endmodule
`default_nettype wire

[rtl/bpa_checker.sv]
`default_nettype none
module bpa_checker import bpa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [63:0]       m_axis_tdata,
	input wire logic [STAT_W-1:0] m_axis_tuser,
	input wire logic              m_axis_tlast
);

	// hold the result item while the sink stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// any failure ends the request
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tlast)
		else $error("failure item without last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 64'd0))
		else $error("failure item carries addresses");

	a_stat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= STAT_NO_PHYS))
		else $error("status code out of range");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while one is in work");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);
`default_nettype wire
